// ===== hdl/tmte_pkg.sv =====
`default_nettype none

package tmte_pkg;

    // Geometry defaults
    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    // Field widths
    localparam int CELL_W    = 16;
    localparam int CODE_W    = 8;
    localparam int COLOR_W   = 4;
    localparam int IDX_W     = 11;
    localparam int COL_OUT_W = 7;
    localparam int ROW_OUT_W = 5;

    localparam logic [CODE_W-1:0]  LINE_FEED  = 8'h0A;
    localparam logic [CODE_W-1:0]  SPACE_CODE = 8'h20;
    localparam logic [COLOR_W-1:0] FG_RESET   = 4'hF;
    localparam logic [COLOR_W-1:0] BG_RESET   = 4'h4;

    typedef enum logic [1:0] {
        KIND_PUT   = 2'd0,
        KIND_ERASE = 2'd1,
        KIND_CLEAR = 2'd2,
        KIND_READ  = 2'd3
    } t_kind;

    typedef enum logic {
        CFG_FG = 1'b0,
        CFG_BG = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        t_kind              kind;
        logic [CODE_W-1:0]  char_code;
        logic [IDX_W-1:0]   cell_index;
    } t_item;

    typedef struct packed {
        logic [CELL_W-1:0]    cell_word;
        logic [COL_OUT_W-1:0] cursor_col;
        logic [ROW_OUT_W-1:0] cursor_row;
    } t_result;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_EXEC,
        S_READ,
        S_SCROLL,
        S_FILL
    } t_state;

    typedef enum logic [2:0] {
        MEM_NONE,
        MEM_WR_CUR,
        MEM_RD_ITEM,
        MEM_SCROLL,
        MEM_FILL_ZERO,
        MEM_FILL_BLANK
    } t_mem_op;

    typedef enum logic [1:0] {
        CUR_HOLD,
        CUR_STEP,
        CUR_HOME
    } t_cur_op;

    typedef struct packed {
        logic    load;
        logic    ptr_clr;
        logic    ptr_inc;
        logic    emit;
        t_mem_op mem_op;
        t_cur_op cur_op;
    } t_dp_cmd;

    typedef struct packed {
        t_kind kind;
        logic  cell_write;
        logic  need_scroll;
        logic  fill_end;
        logic  scroll_end;
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== hdl/tmte_ram.sv =====
`default_nettype none

module tmte_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hdl/tmte_ctrl.sv =====
`default_nettype none

module tmte_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  tmte_pkg::t_dp_stat      i_stat,
    output tmte_pkg::t_dp_cmd       o_cmd,
    output logic                    o_busy
);

    tmte_pkg::t_state r_state;
    tmte_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tmte_pkg::S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_cmd.load    = 1'b0;
        o_cmd.ptr_clr = 1'b0;
        o_cmd.ptr_inc = 1'b0;
        o_cmd.emit    = 1'b0;
        o_cmd.mem_op  = tmte_pkg::MEM_NONE;
        o_cmd.cur_op  = tmte_pkg::CUR_HOLD;

        unique case (r_state)
            tmte_pkg::S_INIT: begin
                o_cmd.mem_op = tmte_pkg::MEM_FILL_ZERO;
                if (i_stat.fill_end) begin
                    o_cmd.ptr_clr = 1'b1;
                    n_state       = tmte_pkg::S_IDLE;
                end else begin
                    o_cmd.ptr_inc = 1'b1;
                end
            end
            tmte_pkg::S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = tmte_pkg::S_EXEC;
                end
            end
            tmte_pkg::S_EXEC: begin
                unique case (i_stat.kind)
                    tmte_pkg::KIND_PUT: begin
                        if (i_stat.cell_write) begin
                            o_cmd.mem_op = tmte_pkg::MEM_WR_CUR;
                        end
                        o_cmd.cur_op = tmte_pkg::CUR_STEP;
                        if (i_stat.need_scroll) begin
                            o_cmd.ptr_clr = 1'b1;
                            n_state       = tmte_pkg::S_SCROLL;
                        end else begin
                            o_cmd.emit = 1'b1;
                            n_state    = tmte_pkg::S_IDLE;
                        end
                    end
                    tmte_pkg::KIND_ERASE: begin
                        if (i_stat.cell_write) begin
                            o_cmd.mem_op = tmte_pkg::MEM_WR_CUR;
                        end
                        o_cmd.cur_op = tmte_pkg::CUR_STEP;
                        o_cmd.emit   = 1'b1;
                        n_state      = tmte_pkg::S_IDLE;
                    end
                    tmte_pkg::KIND_CLEAR: begin
                        o_cmd.ptr_clr = 1'b1;
                        n_state       = tmte_pkg::S_FILL;
                    end
                    tmte_pkg::KIND_READ: begin
                        o_cmd.mem_op = tmte_pkg::MEM_RD_ITEM;
                        n_state      = tmte_pkg::S_READ;
                    end
                endcase
            end
            tmte_pkg::S_READ: begin
                o_cmd.emit = 1'b1;
                n_state    = tmte_pkg::S_IDLE;
            end
            tmte_pkg::S_SCROLL: begin
                o_cmd.mem_op = tmte_pkg::MEM_SCROLL;
                if (i_stat.scroll_end) begin
                    o_cmd.emit = 1'b1;
                    n_state    = tmte_pkg::S_IDLE;
                end else begin
                    o_cmd.ptr_inc = 1'b1;
                end
            end
            tmte_pkg::S_FILL: begin
                o_cmd.mem_op = tmte_pkg::MEM_FILL_BLANK;
                if (i_stat.fill_end) begin
                    o_cmd.cur_op = tmte_pkg::CUR_HOME;
                    o_cmd.emit   = 1'b1;
                    n_state      = tmte_pkg::S_IDLE;
                end else begin
                    o_cmd.ptr_inc = 1'b1;
                end
            end
            default: begin
                n_state = tmte_pkg::S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != tmte_pkg::S_IDLE);

endmodule

`default_nettype wire

// ===== hdl/tmte_dp.sv =====
`default_nettype none

module tmte_dp #(
    parameter int COLUMNS = tmte_pkg::COLUMNS_DEF,
    parameter int ROWS    = tmte_pkg::ROWS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  tmte_pkg::t_item                        i_item,
    input  wire logic                              i_cfg_valid,
    input  tmte_pkg::t_cfg_idx                     i_cfg_index,
    input  wire logic [tmte_pkg::COLOR_W-1:0]      i_cfg_data,
    input  tmte_pkg::t_dp_cmd                      i_cmd,
    output tmte_pkg::t_dp_stat                     o_stat,
    output tmte_pkg::t_result                      o_result,
    output logic                                   o_done
);

    localparam int CELLS      = COLUMNS * ROWS;
    localparam int AW         = $clog2(CELLS);
    localparam int CW         = $clog2(COLUMNS);
    localparam int RW         = $clog2(ROWS);
    localparam int NCOPY      = (ROWS - 2) * COLUMNS;
    localparam int SCROLL_END = (ROWS - 1) * COLUMNS;

    tmte_pkg::t_item                 r_item;
    tmte_pkg::t_result               r_result;
    logic                            r_done;
    logic [CW-1:0]                   r_col;
    logic [CW-1:0]                   n_col;
    logic [RW-1:0]                   r_row;
    logic [RW-1:0]                   n_row;
    logic [AW-1:0]                   r_ptr;
    logic [AW-1:0]                   n_ptr;
    logic [tmte_pkg::COLOR_W-1:0]    r_fg;
    logic [tmte_pkg::COLOR_W-1:0]    r_bg;

    logic [AW-1:0]                   w_cur_addr;
    logic                            w_is_lf;
    logic                            w_wrap;
    logic                            w_row_bottom;
    logic                            w_at_home;
    logic                            w_hit;
    logic [tmte_pkg::CELL_W-1:0]     w_blank;
    logic [31:0]                     w_col_ext;
    logic [31:0]                     w_row_ext;

    logic                            w_we;
    logic [AW-1:0]                   w_waddr;
    logic [tmte_pkg::CELL_W-1:0]     w_wdata;
    logic                            w_re;
    logic [AW-1:0]                   w_raddr;
    logic [tmte_pkg::CELL_W-1:0]     w_rdata;

    tmte_ram #(
        .WIDTH (tmte_pkg::CELL_W),
        .DEPTH (CELLS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_cur_addr   = AW'(r_row) * AW'(COLUMNS) + AW'(r_col);
    assign w_is_lf      = (r_item.char_code == tmte_pkg::LINE_FEED);
    assign w_wrap       = w_is_lf || (r_col == CW'(COLUMNS - 1));
    assign w_row_bottom = (32'(r_row) >= ROWS - 2);
    assign w_at_home    = (r_col == '0) && (r_row == '0);
    assign w_hit        = (32'(r_item.cell_index) < CELLS);
    assign w_blank      = {r_bg, r_fg, tmte_pkg::SPACE_CODE};

    // Cursor update
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        unique case (i_cmd.cur_op)
            tmte_pkg::CUR_HOLD: begin
            end
            tmte_pkg::CUR_HOME: begin
                n_col = '0;
                n_row = '0;
            end
            tmte_pkg::CUR_STEP: begin
                if (r_item.kind == tmte_pkg::KIND_PUT) begin
                    if (w_wrap) begin
                        n_col = '0;
                        // the cursor stays on row ROWS-2, its lowest row; the scroll makes room
                        n_row = w_row_bottom ? r_row : r_row + 1'b1;
                    end else begin
                        n_col = r_col + 1'b1;
                    end
                end else if (r_item.kind == tmte_pkg::KIND_ERASE) begin
                    if (r_col != '0) begin
                        n_col = r_col - 1'b1;
                    end else if (r_row != '0) begin
                        n_col = CW'(COLUMNS - 1);
                        n_row = r_row - 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Memory port selection
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_ptr;
        w_wdata = w_blank;
        w_re    = 1'b0;
        w_raddr = r_ptr;
        unique case (i_cmd.mem_op)
            tmte_pkg::MEM_NONE: begin
            end
            tmte_pkg::MEM_WR_CUR: begin
                w_we = 1'b1;
                if (r_item.kind == tmte_pkg::KIND_PUT) begin
                    w_waddr = w_cur_addr;
                    w_wdata = {r_bg, r_fg, r_item.char_code};
                end else begin
                    // the cell just before the cursor in linear order
                    w_waddr = w_cur_addr - 1'b1;
                end
            end
            tmte_pkg::MEM_RD_ITEM: begin
                w_re    = 1'b1;
                w_raddr = AW'(r_item.cell_index);
            end
            tmte_pkg::MEM_SCROLL: begin
                // read one row ahead, write the beat read last cycle one cell back
                w_re    = (32'(r_ptr) < NCOPY);
                w_raddr = r_ptr + AW'(COLUMNS);
                w_we    = (r_ptr != '0);
                w_waddr = r_ptr - 1'b1;
                w_wdata = (32'(r_ptr) <= NCOPY) ? w_rdata : w_blank;
            end
            tmte_pkg::MEM_FILL_ZERO: begin
                w_we    = 1'b1;
                w_wdata = '0;
            end
            tmte_pkg::MEM_FILL_BLANK: begin
                w_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_ptr = r_ptr;
        if (i_cmd.ptr_clr) begin
            n_ptr = '0;
        end else if (i_cmd.ptr_inc) begin
            n_ptr = r_ptr + 1'b1;
        end
    end

    assign o_stat.kind        = r_item.kind;
    assign o_stat.cell_write  = (r_item.kind == tmte_pkg::KIND_PUT) ? !w_is_lf : !w_at_home;
    assign o_stat.need_scroll = w_wrap && w_row_bottom;
    assign o_stat.fill_end    = (r_ptr == AW'(CELLS - 1));
    assign o_stat.scroll_end  = (32'(r_ptr) == SCROLL_END);

    assign w_col_ext = 32'(n_col);
    assign w_row_ext = 32'(n_row);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_ptr  <= '0;
            r_done <= 1'b0;
            r_fg   <= tmte_pkg::FG_RESET;
            r_bg   <= tmte_pkg::BG_RESET;
        end else begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_ptr  <= n_ptr;
            r_done <= i_cmd.emit;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    tmte_pkg::CFG_FG: r_fg <= i_cfg_data;
                    tmte_pkg::CFG_BG: r_bg <= i_cfg_data;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
        end
        if (i_cmd.emit) begin
            r_result.cell_word  <= (r_item.kind == tmte_pkg::KIND_READ && w_hit) ?
                                   w_rdata : '0;
            r_result.cursor_col <= w_col_ext[tmte_pkg::COL_OUT_W-1:0];
            r_result.cursor_row <= w_row_ext[tmte_pkg::ROW_OUT_W-1:0];
        end
    end

    assign o_result = r_result;
    assign o_done   = r_done;

endmodule

`default_nettype wire

// ===== hdl/text_mode_terminal_engine.sv =====
// Channel   Direction  Handshake                      Payload
// command   in         i_start / o_busy               i_item   (t_item)
// result    out        o_done, one-cycle strobe       o_result (t_result)
// config    in         i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//
// Put and erase execute, then register the result; a read of a cell issues the
// read, captures the read data, then registers the result.
// A put that scrolls then moves rows up in the store, one cell move per cycle.
// Clear blanks the store one cell per cycle, then homes the cursor.
// After reset the store is swept to zero with o_busy high.
// Results are strobed for one cycle and cannot be held off; config is always ready.
`default_nettype none

module text_mode_terminal_engine #(
    parameter int COLUMNS = tmte_pkg::COLUMNS_DEF,
    parameter int ROWS    = tmte_pkg::ROWS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    output logic                                   o_busy,
    input  tmte_pkg::t_item                        i_item,
    output logic                                   o_done,
    output tmte_pkg::t_result                      o_result,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  tmte_pkg::t_cfg_idx                     i_cfg_index,
    input  wire logic [tmte_pkg::COLOR_W-1:0]      i_cfg_data
);

    tmte_pkg::t_dp_cmd  w_cmd;
    tmte_pkg::t_dp_stat w_stat;

    tmte_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (o_busy)
    );

    tmte_dp #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_result    (o_result),
        .o_done      (o_done)
    );

    assign o_cfg_ready = 1'b1;

endmodule

`default_nettype wire
